// ===== hdl/indexed_list_insert_delete_unit_assert.svh =====
// Assertion macros for the indexed list insert/delete unit.
// Included by indexed_list_insert_delete_unit, which carries the concurrent assertions; no other dependencies.
`ifndef INDEXED_LIST_INSERT_DELETE_UNIT_ASSERT_SVH
`define INDEXED_LIST_INSERT_DELETE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Check prop at every clk edge while out of reset.
`define ILID_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check an implication at every clk edge while out of reset.
`define ILID_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ILID_ASSERT(lbl, clk, rst_n, prop, msg)
`define ILID_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/ilid_pkg.sv =====
// Shared types and constants of the indexed list insert/delete unit.
// No dependencies; used by ilid_cell and indexed_list_insert_delete_unit.
package ilid_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int IDX_W        = 11;   // holds any position or count up to 1024
  localparam int DATA_W       = 32;
  localparam int GRP_N        = 32;   // cells per read-reduction group

  localparam logic [2:0] OP_READ     = 3'd0;
  localparam logic [2:0] OP_INS_HEAD = 3'd1;
  localparam logic [2:0] OP_INS_TAIL = 3'd2;
  localparam logic [2:0] OP_INS_AT   = 3'd3;
  localparam logic [2:0] OP_DELETE   = 3'd4;
  localparam logic [2:0] OP_CLEAR    = 3'd5;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic              ins;
    logic              del;
    logic              rd;
    logic [IDX_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage

// ===== hdl/ilid_cell.sv =====
// One list slot: holds an entry and shifts toward head or tail on request.
// Depends on ilid_pkg.
module ilid_cell #(
  parameter int INDEX = 0
) (
  input  logic                        clk,
  input  ilid_pkg::cell_ctl_t         ctl,
  input  logic [ilid_pkg::DATA_W-1:0] prev_q,   // entry of the slot toward the head
  input  logic [ilid_pkg::DATA_W-1:0] next_q,   // entry of the slot toward the tail
  output logic [ilid_pkg::DATA_W-1:0] q,
  output logic [ilid_pkg::DATA_W-1:0] rd_q      // own entry if read hit, else zero
);

  localparam logic [ilid_pkg::IDX_W-1:0] IDX = ilid_pkg::IDX_W'(INDEX);

  logic [ilid_pkg::DATA_W-1:0] q_r, q_nxt;
  logic [ilid_pkg::DATA_W-1:0] rd_r, rd_nxt;
  logic                        hit;
  logic                        above;

  assign hit   = (IDX == ctl.pos);
  assign above = (IDX > ctl.pos);

  always_comb begin
    q_nxt = q_r;
    if (ctl.ins) begin
      if (above) q_nxt = prev_q;
      else if (hit) q_nxt = ctl.value;
    end else if (ctl.del) begin
      if (above || hit) q_nxt = next_q;
    end
    rd_nxt = (ctl.rd && hit) ? q_r : '0;
  end

  always_ff @(posedge clk) begin
    q_r  <= q_nxt;
    rd_r <= rd_nxt;
  end

  assign q    = q_r;
  assign rd_q = rd_r;

endmodule

// ===== hdl/indexed_list_insert_delete_unit.sv =====
// Top level of the indexed list insert/delete unit: sequencer, count and read tree.
// Depends on ilid_pkg, ilid_cell and indexed_list_insert_delete_unit_assert.svh.
//
// Usage:
//   Requests enter on the in_ stream: in_tuser carries op, in_tdata carries
//   position and value_in. Each request yields exactly one result on the out_
//   stream: out_tuser carries status, out_tdata carries value_out and count.
//   The list lives in a row of CAPACITY cells; an insert or delete moves every
//   cell at or past the position one slot during the execute step.
//   Steps: a request is accepted in the idle step, then passes through execute,
//   group reduce, then final reduce and output load together.
//   The block takes no new request until the previous result is loaded into
//   the output register; once that load is done the next request can be
//   taken, so a waiting result does not hold back the next request. The
//   four sequencer steps are idle, execute, group, final.
//   Reset (rst_n low, synchronous) empties the list and drops any pending
//   result; entry contents are not cleared and are never read before written.
//   If the receiver stalls, the result holds in the output register and the
//   block completes at most one further request, then waits in its final
//   step until out_tready rises.
module indexed_list_insert_delete_unit #(
  parameter int CAPACITY = ilid_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // [6:0] position, [38:7] value_in, [39] zero
  input  logic [2:0]  in_tuser,    // [2:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // [31:0] value_out, [38:32] count, [39] zero
  output logic [1:0]  out_tuser    // [1:0] status
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int NG = (CAPACITY + ilid_pkg::GRP_N - 1) / ilid_pkg::GRP_N;
  localparam int DW = ilid_pkg::DATA_W;
  localparam int IW = ilid_pkg::IDX_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_GRP  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // Latched request
  logic          ins_r, del_r, rd_r, rd_bad_r;
  logic [IW-1:0] pos_r;
  logic [DW-1:0] val_r;
  logic [1:0]    st_r;
  logic [IW-1:0] cnt_snap_r;

  // Output register
  logic          out_valid_r;
  logic [DW-1:0] out_val_r;
  logic [1:0]    out_st_r;
  logic [6:0]    out_cnt_r;

  logic [DW-1:0] grp_r [NG];
  logic [DW-1:0] grp_nxt [NG];
  logic [DW-1:0] fin_or;

  logic [2:0]    in_op;
  logic [IW-1:0] in_pos, cnt_ext, eff_pos;
  logic [DW-1:0] in_val;
  logic          accept, load_out, full, pos_lt_cnt, pos_gt_cnt;
  logic [1:0]    st_new;
  logic          ins_ok, del_ok, rd_ok, rd_bad;

  ilid_pkg::cell_ctl_t ctl;
  logic [DW-1:0] cell_q  [CAPACITY];
  logic [DW-1:0] cell_rd [CAPACITY];

  assign in_op   = in_tuser;
  assign in_pos  = IW'(in_tdata[6:0]);
  assign in_val  = in_tdata[38:7];
  assign cnt_ext = IW'(count_r);

  assign full       = (count_r >= CW'(CAPACITY));
  assign pos_lt_cnt = (in_pos < cnt_ext);
  assign pos_gt_cnt = (in_pos > cnt_ext);

  assign load_out  = (state_r == S_FIN) && (!out_valid_r || out_tready);
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Decode the operation against the current count
  always_comb begin
    st_new  = ilid_pkg::ST_DONE;
    ins_ok  = 1'b0;
    del_ok  = 1'b0;
    rd_ok   = 1'b0;
    rd_bad  = 1'b0;
    eff_pos = in_pos;
    case (in_op)
      ilid_pkg::OP_READ: begin
        if (pos_lt_cnt) rd_ok = 1'b1;
        else begin
          rd_bad = 1'b1;
          st_new = ilid_pkg::ST_RANGE;
        end
      end
      ilid_pkg::OP_INS_HEAD, ilid_pkg::OP_INS_TAIL: begin
        eff_pos = (in_op == ilid_pkg::OP_INS_HEAD) ? '0 : cnt_ext;
        if (full) st_new = ilid_pkg::ST_FULL;
        else ins_ok = 1'b1;
      end
      ilid_pkg::OP_INS_AT: begin
        if (pos_gt_cnt) st_new = ilid_pkg::ST_RANGE;
        else if (full) st_new = ilid_pkg::ST_FULL;
        else ins_ok = 1'b1;
      end
      ilid_pkg::OP_DELETE: begin
        if (pos_lt_cnt) del_ok = 1'b1;
        else st_new = ilid_pkg::ST_RANGE;
      end
      ilid_pkg::OP_CLEAR: ;
      default: st_new = ilid_pkg::ST_RANGE;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      if (ins_ok) count_nxt = count_r + CW'(1);
      else if (del_ok) count_nxt = count_r - CW'(1);
      else if (in_op == ilid_pkg::OP_CLEAR) count_nxt = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_GRP;
      S_GRP:  state_nxt = S_FIN;
      S_FIN:  if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      ins_r       <= 1'b0;
      del_r       <= 1'b0;
      rd_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (accept) begin
        ins_r <= ins_ok;
        del_r <= del_ok;
        rd_r  <= rd_ok;
      end
    end
  end

  // Request payload: hold from accept until the result is loaded
  always_ff @(posedge clk) begin
    if (accept) begin
      pos_r      <= eff_pos;
      val_r      <= in_val;
      st_r       <= st_new;
      rd_bad_r   <= rd_bad;
      cnt_snap_r <= IW'(count_nxt);
    end
    if (load_out) begin
      out_val_r <= rd_bad_r ? {DW{1'b1}} : fin_or;
      out_st_r  <= st_r;
      out_cnt_r <= cnt_snap_r[6:0];
    end
  end

  // Drive the cell row only during the execute step
  always_comb begin
    ctl.ins   = (state_r == S_EXEC) && ins_r;
    ctl.del   = (state_r == S_EXEC) && del_r;
    ctl.rd    = (state_r == S_EXEC) && rd_r;
    ctl.pos   = pos_r;
    ctl.value = val_r;
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DW-1:0] prev_q, next_q;
    if (k == 0) begin : g_head
      assign prev_q = '0;
    end else begin : g_mid_p
      assign prev_q = cell_q[k-1];
    end
    if (k == CAPACITY - 1) begin : g_tail
      assign next_q = '0;
    end else begin : g_mid_n
      assign next_q = cell_q[k+1];
    end
    ilid_cell #(.INDEX(k)) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .prev_q (prev_q),
      .next_q (next_q),
      .q      (cell_q[k]),
      .rd_q   (cell_rd[k])
    );
  end

  // Read tree: OR each group of cells, register, then OR the groups
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < ilid_pkg::GRP_N; j++) begin
        if (g * ilid_pkg::GRP_N + j < CAPACITY)
          grp_nxt[g] = grp_nxt[g] | cell_rd[g * ilid_pkg::GRP_N + j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_GRP) begin
      for (int g = 0; g < NG; g++) grp_r[g] <= grp_nxt[g];
    end
  end

  always_comb begin
    fin_or = '0;
    for (int g = 0; g < NG; g++) fin_or = fin_or | grp_r[g];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_cnt_r, out_val_r};
  assign out_tuser  = out_st_r;

`include "indexed_list_insert_delete_unit_assert.svh"

  `ILID_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(CAPACITY), "count above capacity")
  `ILID_ASSERT_IMP(a_accept_exec, clk, rst_n, accept, state_r == S_EXEC, "accept not executed")
  `ILID_ASSERT_IMP(a_ins_count, clk, rst_n, accept && ins_ok, count_r == $past(count_r) + CW'(1), "insert count")
  `ILID_ASSERT_IMP(a_load_valid, clk, rst_n, load_out, out_valid_r, "result not presented")

endmodule
